// ===== src/msfe_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Shared types, constants and the CRC-8/MAXIM byte step of the motor serial frame engine.
// No dependencies; every other file imports this package.
package msfe_pkg;

    localparam int FRAME_BYTES = 10;
    localparam int QUEUE_DEPTH = 4;

    localparam logic [7:0] CRC_POLY   = 8'h8c;
    localparam logic [7:0] MODE_DRIVE = 8'h64;
    localparam logic [7:0] MODE_INFO  = 8'h74;

    // input commands
    localparam logic [1:0] CMD_DRIVE = 2'd0;
    localparam logic [1:0] CMD_INFO  = 2'd1;
    localparam logic [1:0] CMD_RX    = 2'd2;

    // result kinds
    localparam logic [1:0] KIND_TX      = 2'd0;
    localparam logic [1:0] KIND_GOOD    = 2'd1;
    localparam logic [1:0] KIND_CRC_ERR = 2'd2;

    // byte positions inside a transmitted frame
    localparam logic [3:0] FB_ID     = 4'd0;
    localparam logic [3:0] FB_MODE   = 4'd1;
    localparam logic [3:0] FB_CMD_HI = 4'd2;
    localparam logic [3:0] FB_CMD_LO = 4'd3;
    localparam logic [3:0] FB_ZERO_A = 4'd4;
    localparam logic [3:0] FB_ZERO_B = 4'd5;
    localparam logic [3:0] FB_ACCEL  = 4'd6;
    localparam logic [3:0] FB_BRAKE  = 4'd7;
    localparam logic [3:0] FB_RESV   = 4'd8;
    localparam logic [3:0] FB_CRC    = 4'(FRAME_BYTES - 1);

    typedef struct packed {
        logic [1:0]  result_kind;
        logic [7:0]  tx_byte;
        logic        last_of_run;
        logic [7:0]  reply_id;
        logic [7:0]  reply_mode;
        logic [15:0] torque;
        logic [15:0] speed;
        logic [15:0] position;
        logic [7:0]  temperature;
        logic [7:0]  extra_byte;
        logic [7:0]  fault;
        logic        was_info_reply;
    } result_t;

    // Send jobs reuse the result fields: reply_id = motor id, reply_mode = mode byte,
    // torque = drive word, speed = {accel_time, brake}.
    typedef struct packed {
        logic    is_send;
        result_t res;
    } job_t;

    function automatic logic [7:0] crc_step(input logic [7:0] crc, input logic [7:0] data);
        logic [7:0] c;
        c = crc ^ data;
        for (int i = 0; i < 8; i++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage
`default_nettype wire

// ===== src/msfe_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Front end: accepts input items, gathers received frames, checks their CRC and
// posts send and report jobs to the job queue. Depends on msfe_pkg.
module msfe_front (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_fire,
    input  wire logic [1:0]        command,
    input  wire logic [7:0]        motor_id,
    input  wire logic [15:0]       drive_value,
    input  wire logic [7:0]        accel_time,
    input  wire logic [7:0]        brake,
    input  wire logic [7:0]        rx_byte,
    output logic                   job_push,
    output msfe_pkg::job_t         job
);
    import msfe_pkg::*;

    localparam logic [3:0] RX_LAST = 4'(FRAME_BYTES - 1);

    logic [3:0]  rx_count_reg, rx_count_next;
    logic [7:0]  rx_crc_reg, rx_crc_next;
    logic [7:0]  rx_bytes_reg [FRAME_BYTES - 1];
    logic        rx_wr;
    logic        info_pending_reg, info_pending_next;
    logic [15:0] held_position_reg, held_position_next;
    logic [7:0]  held_temperature_reg, held_temperature_next;
    logic [7:0]  held_extra_reg, held_extra_next;

    always_comb begin
        rx_count_next         = rx_count_reg;
        rx_crc_next           = rx_crc_reg;
        info_pending_next     = info_pending_reg;
        held_position_next    = held_position_reg;
        held_temperature_next = held_temperature_reg;
        held_extra_next       = held_extra_reg;
        rx_wr                 = 1'b0;
        job_push              = 1'b0;
        job                   = '0;
        if (in_fire) begin
            unique case (command)
                CMD_DRIVE: begin
                    job.is_send        = 1'b1;
                    job.res.reply_id   = motor_id;
                    job.res.reply_mode = MODE_DRIVE;
                    job.res.torque     = drive_value;
                    job.res.speed      = {accel_time, brake};
                    job_push           = 1'b1;
                    rx_count_next      = '0;
                    rx_crc_next        = '0;
                end
                CMD_INFO: begin
                    job.is_send        = 1'b1;
                    job.res.reply_id   = motor_id;
                    job.res.reply_mode = MODE_INFO;
                    job_push           = 1'b1;
                    info_pending_next  = 1'b1;
                    rx_count_next      = '0;
                    rx_crc_next        = '0;
                end
                CMD_RX: begin
                    if (rx_count_reg < RX_LAST) begin
                        rx_wr         = 1'b1;
                        rx_crc_next   = crc_step(rx_crc_reg, rx_byte);
                        rx_count_next = rx_count_reg + 4'd1;
                    end else begin
                        job_push            = 1'b1;
                        job.res.last_of_run = 1'b1;
                        rx_count_next       = '0;
                        rx_crc_next         = '0;
                        if (rx_byte != rx_crc_reg) begin
                            job.res.result_kind = KIND_CRC_ERR;
                        end else begin
                            job.res.result_kind = KIND_GOOD;
                            job.res.reply_id    = rx_bytes_reg[0];
                            job.res.reply_mode  = rx_bytes_reg[1];
                            job.res.torque      = {rx_bytes_reg[2], rx_bytes_reg[3]};
                            job.res.speed       = {rx_bytes_reg[4], rx_bytes_reg[5]};
                            job.res.fault       = rx_bytes_reg[8];
                            if (info_pending_reg) begin
                                held_temperature_next  = rx_bytes_reg[6];
                                held_extra_next        = rx_bytes_reg[7];
                                info_pending_next      = 1'b0;
                                job.res.was_info_reply = 1'b1;
                            end else begin
                                held_position_next = {rx_bytes_reg[6], rx_bytes_reg[7]};
                            end
                            job.res.position    = held_position_next;
                            job.res.temperature = held_temperature_next;
                            job.res.extra_byte  = held_extra_next;
                        end
                    end
                end
                default: begin
                    // unused command: drop
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            rx_count_reg         <= '0;
            rx_crc_reg           <= '0;
            info_pending_reg     <= 1'b0;
            held_position_reg    <= '0;
            held_temperature_reg <= '0;
            held_extra_reg       <= '0;
        end else begin
            rx_count_reg         <= rx_count_next;
            rx_crc_reg           <= rx_crc_next;
            info_pending_reg     <= info_pending_next;
            held_position_reg    <= held_position_next;
            held_temperature_reg <= held_temperature_next;
            held_extra_reg       <= held_extra_next;
        end
    end

    always_ff @(posedge clk) begin
        if (rx_wr) begin
            rx_bytes_reg[rx_count_reg] <= rx_byte;
        end
    end

endmodule
`default_nettype wire

// ===== src/msfe_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Short job queue between front and back end, QUEUE_DEPTH entries of job_t.
// Depends on msfe_pkg.
module msfe_queue (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    input  wire msfe_pkg::job_t    wdata,
    output logic                   full,
    output logic                   empty,
    input  wire logic              pop,
    output msfe_pkg::job_t         rdata
);
    import msfe_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);

    job_t             mem_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push, do_pop;

    assign full    = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule
`default_nettype wire

// ===== src/msfe_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Back end: takes jobs from the queue, serializes send frames with a running CRC
// and holds one result beat in the output register. Depends on msfe_pkg.
module msfe_back (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              q_empty,
    input  wire msfe_pkg::job_t    q_job,
    output logic                   q_pop,
    output logic                   out_valid,
    input  wire logic              out_pop,
    output msfe_pkg::result_t      out_res
);
    import msfe_pkg::*;

    logic       out_valid_reg, out_valid_next;
    result_t    out_res_reg, out_res_next;
    logic       send_active_reg, send_active_next;
    logic [3:0] byte_idx_reg, byte_idx_next;
    logic [7:0] crc_reg, crc_next;
    result_t    send_job_reg, send_job_next;
    logic       advance;
    logic [7:0] frame_byte;

    assign advance   = !out_valid_reg || out_pop;
    assign out_valid = out_valid_reg;
    assign out_res   = out_res_reg;

    always_comb begin
        unique case (byte_idx_reg)
            FB_ID:     frame_byte = send_job_reg.reply_id;
            FB_MODE:   frame_byte = send_job_reg.reply_mode;
            FB_CMD_HI: frame_byte = send_job_reg.torque[15:8];
            FB_CMD_LO: frame_byte = send_job_reg.torque[7:0];
            FB_ACCEL:  frame_byte = send_job_reg.speed[15:8];
            FB_BRAKE:  frame_byte = send_job_reg.speed[7:0];
            FB_CRC:    frame_byte = crc_reg;
            default:   frame_byte = 8'h00;
        endcase
    end

    always_comb begin
        out_valid_next   = out_valid_reg;
        out_res_next     = out_res_reg;
        send_active_next = send_active_reg;
        byte_idx_next    = byte_idx_reg;
        crc_next         = crc_reg;
        send_job_next    = send_job_reg;
        q_pop            = 1'b0;
        if (advance) begin
            out_valid_next = 1'b0;
            if (send_active_reg) begin
                out_valid_next   = 1'b1;
                out_res_next     = '0;
                out_res_next.result_kind = KIND_TX;
                out_res_next.tx_byte     = frame_byte;
                crc_next         = crc_step(crc_reg, frame_byte);
                byte_idx_next    = byte_idx_reg + 4'd1;
                if (byte_idx_reg == FB_CRC) begin
                    out_res_next.last_of_run = 1'b1;
                    send_active_next         = 1'b0;
                end
            end else if (!q_empty) begin
                q_pop          = 1'b1;
                out_valid_next = 1'b1;
                if (q_job.is_send) begin
                    // emit the id byte now, continue from the mode byte
                    out_res_next             = '0;
                    out_res_next.result_kind = KIND_TX;
                    out_res_next.tx_byte     = q_job.res.reply_id;
                    send_job_next            = q_job.res;
                    crc_next                 = crc_step(8'h00, q_job.res.reply_id);
                    byte_idx_next            = FB_MODE;
                    send_active_next         = 1'b1;
                end else begin
                    out_res_next = q_job.res;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            out_valid_reg   <= 1'b0;
            send_active_reg <= 1'b0;
        end else begin
            out_valid_reg   <= out_valid_next;
            send_active_reg <= send_active_next;
        end
    end

    always_ff @(posedge clk) begin
        out_res_reg  <= out_res_next;
        byte_idx_reg <= byte_idx_next;
        crc_reg      <= crc_next;
        send_job_reg <= send_job_next;
    end

endmodule
`default_nettype wire

// ===== src/motor_serial_frame_engine_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Top level of the motor serial frame engine: front end, job queue, back end.
// Depends on msfe_pkg, msfe_front, msfe_queue and msfe_back.
//
// Input items are taken one per cycle while the four-entry job queue has room; a
// received byte that does not end a frame is absorbed in that cycle with no result.
// A drive or info request turns into ten transmit beats and a completed receive frame
// into one report beat. The job is queued at the accepting edge and, when the back end
// is free, loaded into its output register at the next edge. The back end delivers one
// beat per cycle while results are popped, so a send job holds the result side for all
// ten of its beats; the queue fills, and full rises, when requests come faster than
// the back end sends their beats or when results are taken slowly. Results leave in
// input order.
module motor_serial_frame_engine_top (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push,
    output logic                    full,
    input  wire logic [1:0]         command,
    input  wire logic [7:0]         motor_id,
    input  wire logic signed [15:0] drive_value,
    input  wire logic [7:0]         accel_time,
    input  wire logic [7:0]         brake,
    input  wire logic [7:0]         rx_byte,
    output logic                    empty,
    input  wire logic               pop,
    output logic [1:0]              result_kind,
    output logic [7:0]              tx_byte,
    output logic                    last_of_run,
    output logic [7:0]              reply_id,
    output logic [7:0]              reply_mode,
    output logic signed [15:0]      torque,
    output logic signed [15:0]      speed,
    output logic [15:0]             position,
    output logic [7:0]              temperature,
    output logic [7:0]              extra_byte,
    output logic [7:0]              fault,
    output logic                    was_info_reply
);
    import msfe_pkg::*;

    logic    in_fire;
    logic    job_push;
    job_t    job_in, job_out;
    logic    q_full, q_empty, q_pop;
    logic    out_valid;
    result_t res;

    assign full    = q_full;
    assign in_fire = push && !q_full;

    msfe_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_fire     (in_fire),
        .command     (command),
        .motor_id    (motor_id),
        .drive_value (drive_value),
        .accel_time  (accel_time),
        .brake       (brake),
        .rx_byte     (rx_byte),
        .job_push    (job_push),
        .job         (job_in)
    );

    msfe_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (job_push),
        .wdata (job_in),
        .full  (q_full),
        .empty (q_empty),
        .pop   (q_pop),
        .rdata (job_out)
    );

    msfe_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (q_empty),
        .q_job     (job_out),
        .q_pop     (q_pop),
        .out_valid (out_valid),
        .out_pop   (pop),
        .out_res   (res)
    );

    assign empty          = !out_valid;
    assign result_kind    = res.result_kind;
    assign tx_byte        = res.tx_byte;
    assign last_of_run    = res.last_of_run;
    assign reply_id       = res.reply_id;
    assign reply_mode     = res.reply_mode;
    assign torque         = res.torque;
    assign speed          = res.speed;
    assign position       = res.position;
    assign temperature    = res.temperature;
    assign extra_byte     = res.extra_byte;
    assign fault          = res.fault;
    assign was_info_reply = res.was_info_reply;

endmodule
`default_nettype wire

// ===== test/tb_motor_serial_frame_engine_top.sv =====
`timescale 1ns / 1ps
// Testbench for motor_serial_frame_engine_top: sends drive and info requests and received
// bytes, predicts every transmit and report beat in a scoreboard and checks them in order.
// Depends on msfe_pkg and the top level under src.
module tb_motor_serial_frame_engine_top;
    import msfe_pkg::*;

    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam int RX_BODY = FRAME_BYTES - 1;
    localparam int IDLE_LIMIT = 2000;
    localparam int SETTLE_CYCLES = 20;

    typedef logic [7:0] frame_body_t [RX_BODY];
    typedef enum {STALL_NONE, STALL_LIGHT, STALL_HEAVY} stall_mode_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                push = 1'b0;
    logic [1:0]          command = CMD_DRIVE;
    logic [7:0]          motor_id = 8'h00;
    logic signed [15:0]  drive_value = 16'sh0000;
    logic [7:0]          accel_time = 8'h00;
    logic [7:0]          brake = 8'h00;
    logic [7:0]          rx_byte = 8'h00;
    logic                pop = 1'b0;
    logic                full;
    logic                empty;
    logic [1:0]          result_kind;
    logic [7:0]          tx_byte;
    logic                last_of_run;
    logic [7:0]          reply_id;
    logic [7:0]          reply_mode;
    logic signed [15:0]  torque;
    logic signed [15:0]  speed;
    logic [15:0]         position;
    logic [7:0]          temperature;
    logic [7:0]          extra_byte;
    logic [7:0]          fault;
    logic                was_info_reply;

    // link state as the block should hold it
    logic [3:0]          rx_fill = 4'd0;
    logic [7:0]          rx_crc_acc = 8'h00;
    logic [7:0]          rx_held [RX_BODY];
    bit                  info_due = 1'b0;
    logic [15:0]         pos_held = 16'h0000;
    logic [7:0]          temp_held = 8'h00;
    logic [7:0]          extra_held = 8'h00;

    result_t             link_beats_due [$];
    int                  errors = 0;
    int                  items_accepted = 0;
    int                  idle_cycles = 0;
    int                  burst_left = 0;
    bit                  sender_idle = 1'b1;
    stall_mode_t         stall_mode = STALL_LIGHT;
    int                  stall_left = 0;

    motor_serial_frame_engine_top dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .push           (push),
        .full           (full),
        .command        (command),
        .motor_id       (motor_id),
        .drive_value    (drive_value),
        .accel_time     (accel_time),
        .brake          (brake),
        .rx_byte        (rx_byte),
        .empty          (empty),
        .pop            (pop),
        .result_kind    (result_kind),
        .tx_byte        (tx_byte),
        .last_of_run    (last_of_run),
        .reply_id       (reply_id),
        .reply_mode     (reply_mode),
        .torque         (torque),
        .speed          (speed),
        .position       (position),
        .temperature    (temperature),
        .extra_byte     (extra_byte),
        .fault          (fault),
        .was_info_reply (was_info_reply)
    );

    always #1 clk = ~clk;

    // bit-serial form of the reflected CRC-8
    function automatic logic [7:0] maxim_crc_byte(input logic [7:0] crc, input logic [7:0] data);
        logic [7:0] c;
        logic       fb;
        c = crc;
        for (int i = 0; i < 8; i++)
        begin
            fb = c[0] ^ data[i];
            c = c >> 1;
            if (fb)
                c = c ^ CRC_POLY;
        end
        return c;
    endfunction

    task automatic predict_link_beats(input logic [1:0] cmd, input logic [7:0] id,
                                      input logic [15:0] dv, input logic [7:0] acc,
                                      input logic [7:0] brk, input logic [7:0] rxb);
        logic [7:0] frame [FRAME_BYTES];
        logic [7:0] crc;
        result_t    r;
        if (cmd == CMD_DRIVE || cmd == CMD_INFO)
        begin
            foreach (frame[i])
                frame[i] = 8'h00;
            frame[FB_ID] = id;
            if (cmd == CMD_DRIVE)
            begin
                frame[FB_MODE]   = MODE_DRIVE;
                frame[FB_CMD_HI] = dv[15:8];
                frame[FB_CMD_LO] = dv[7:0];
                frame[FB_ACCEL]  = acc;
                frame[FB_BRAKE]  = brk;
            end
            else
            begin
                frame[FB_MODE] = MODE_INFO;
                info_due = 1'b1;
            end
            crc = 8'h00;
            for (int i = 0; i < RX_BODY; i++)
                crc = maxim_crc_byte(crc, frame[i]);
            frame[FB_CRC] = crc;
            for (int i = 0; i < FRAME_BYTES; i++)
            begin
                r = '0;
                r.result_kind = KIND_TX;
                r.tx_byte = frame[i];
                r.last_of_run = (i == FRAME_BYTES - 1);
                link_beats_due.push_back(r);
            end
            rx_fill = 4'd0;
            rx_crc_acc = 8'h00;
        end
        else if (cmd == CMD_RX)
        begin
            if (rx_fill < RX_BODY)
            begin
                rx_held[rx_fill] = rxb;
                rx_crc_acc = maxim_crc_byte(rx_crc_acc, rxb);
                rx_fill = rx_fill + 4'd1;
            end
            else
            begin
                r = '0;
                r.last_of_run = 1'b1;
                if (rxb != rx_crc_acc)
                    r.result_kind = KIND_CRC_ERR;
                else
                begin
                    r.result_kind = KIND_GOOD;
                    r.reply_id = rx_held[0];
                    r.reply_mode = rx_held[1];
                    r.torque = {rx_held[2], rx_held[3]};
                    r.speed = {rx_held[4], rx_held[5]};
                    if (info_due)
                    begin
                        temp_held = rx_held[6];
                        extra_held = rx_held[7];
                        r.was_info_reply = 1'b1;
                        info_due = 1'b0;
                    end
                    else
                        pos_held = {rx_held[6], rx_held[7]};
                    r.position = pos_held;
                    r.temperature = temp_held;
                    r.extra_byte = extra_held;
                    r.fault = rx_held[8];
                end
                link_beats_due.push_back(r);
                rx_fill = 4'd0;
                rx_crc_acc = 8'h00;
            end
        end
    endtask

    // Called at a rising edge; returns at the edge that accepts the beat, push still high.
    task automatic push_beat(input logic [1:0] cmd, input logic [7:0] id, input logic [15:0] dv,
                             input logic [7:0] acc, input logic [7:0] brk, input logic [7:0] rxb);
        if (sender_idle)
        begin
            if (burst_left == 0)
            begin
                push <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge clk);
                burst_left = $urandom_range(1, 12);
            end
            burst_left--;
        end
        push        <= 1'b1;
        command     <= cmd;
        motor_id    <= id;
        drive_value <= dv;
        accel_time  <= acc;
        brake       <= brk;
        rx_byte     <= rxb;
        do
            @(posedge clk);
        while (full);
        predict_link_beats(cmd, id, dv, acc, brk, rxb);
        items_accepted++;
    endtask

    task automatic send_drive(input logic [7:0] id, input logic [15:0] dv,
                              input logic [7:0] acc, input logic [7:0] brk);
        push_beat(CMD_DRIVE, id, dv, acc, brk, 8'($urandom_range(0, 255)));
    endtask

    task automatic send_info(input logic [7:0] id);
        push_beat(CMD_INFO, id, 16'($urandom), 8'($urandom_range(0, 255)),
                  8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
    endtask

    task automatic send_rx(input logic [7:0] b);
        push_beat(CMD_RX, 8'($urandom_range(0, 255)), 16'($urandom),
                  8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), b);
    endtask

    task automatic send_ignored();
        push_beat(CMD_UNUSED, 8'($urandom_range(0, 255)), 16'($urandom),
                  8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                  8'($urandom_range(0, 255)));
    endtask

    // Nine body bytes then the CRC byte, corrupted unless good; an ignored command
    // goes in front of body byte ignored_at (none when negative).
    task automatic send_reply_frame(input frame_body_t body, input bit good, input int ignored_at);
        logic [7:0] crc;
        crc = 8'h00;
        for (int i = 0; i < RX_BODY; i++)
        begin
            if (i == ignored_at)
                send_ignored();
            send_rx(body[i]);
            crc = maxim_crc_byte(crc, body[i]);
        end
        send_rx(good ? crc : crc ^ 8'($urandom_range(1, 255)));
    endtask

    task automatic hold_until_drained();
        push <= 1'b0;
        do
            @(posedge clk);
        while (link_beats_due.size() != 0);
        burst_left = 0;
    endtask

    task automatic test_send_extremes();
        send_drive(8'hFF, 16'h8000, 8'hFF, 8'hFF);
        send_drive(8'h00, 16'h7FFF, 8'h00, 8'h00);
        send_info(8'h5A);
    endtask

    // A CRC error must keep the info mark, so the next good frame still decodes as info.
    task automatic test_info_reply_after_crc_error();
        frame_body_t body;
        foreach (body[i])
            body[i] = 8'($urandom_range(0, 255));
        send_reply_frame(body, 1'b0, 4);
        body = '{8'h01, MODE_INFO, 8'h80, 8'h00, 8'h7F, 8'hFF, 8'hFF, 8'h00, 8'hFF};
        send_reply_frame(body, 1'b1, -1);
    endtask

    task automatic test_random_traffic(input int count, input bit idle, input stall_mode_t stall);
        int          stop_at;
        int          pick;
        frame_body_t body;
        stop_at = items_accepted + count;
        sender_idle = idle;
        stall_mode = stall;
        while (items_accepted < stop_at)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 55)
            begin
                foreach (body[i])
                    body[i] = 8'($urandom_range(0, 255));
                if ($urandom_range(0, 3) == 0)
                    body[1] = $urandom_range(0, 1) ? MODE_DRIVE : MODE_INFO;
                send_reply_frame(body, $urandom_range(0, 9) != 0,
                                 ($urandom_range(0, 4) == 0) ? int'($urandom_range(0, RX_BODY - 1))
                                                             : -1);
            end
            else if (pick < 72)
                send_drive(8'($urandom_range(0, 255)), 16'($urandom),
                           8'($urandom_range(0, 255)),
                           $urandom_range(0, 3) == 0 ? 8'hFF : 8'($urandom_range(0, 255)));
            else if (pick < 82)
                send_info(8'($urandom_range(0, 255)));
            else if (pick < 94)
            begin
                // broken frame, cut short by a request that restarts the receive side
                repeat ($urandom_range(1, RX_BODY))
                    send_rx(8'($urandom_range(0, 255)));
                if ($urandom_range(0, 1))
                    send_info(8'($urandom_range(0, 255)));
                else
                    send_drive(8'($urandom_range(0, 255)), 16'($urandom),
                               8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
            end
            else
                send_ignored();
        end
    endtask

    function automatic void check_field(input string name, input logic [15:0] want,
                                        input logic [15:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            errors++;
        end
    endfunction

    task automatic check_beat();
        result_t want;
        result_t got;
        got = {result_kind, tx_byte, last_of_run, reply_id, reply_mode, torque, speed,
               position, temperature, extra_byte, fault, was_info_reply};
        if (link_beats_due.size() == 0)
        begin
            $error("result beat with none expected: result_kind %0d", got.result_kind);
            errors++;
        end
        else
        begin
            want = link_beats_due.pop_front();
            check_field("result_kind", 16'(want.result_kind), 16'(got.result_kind));
            check_field("tx_byte", 16'(want.tx_byte), 16'(got.tx_byte));
            check_field("last_of_run", 16'(want.last_of_run), 16'(got.last_of_run));
            check_field("reply_id", 16'(want.reply_id), 16'(got.reply_id));
            check_field("reply_mode", 16'(want.reply_mode), 16'(got.reply_mode));
            check_field("torque", want.torque, got.torque);
            check_field("speed", want.speed, got.speed);
            check_field("position", want.position, got.position);
            check_field("temperature", 16'(want.temperature), 16'(got.temperature));
            check_field("extra_byte", 16'(want.extra_byte), 16'(got.extra_byte));
            check_field("fault", 16'(want.fault), 16'(got.fault));
            check_field("was_info_reply", 16'(want.was_info_reply), 16'(got.was_info_reply));
        end
    endtask

    // result side: check the beat taken at this edge, then pick pop for the next one
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (pop && !empty)
                check_beat();
            if (stall_left > 0)
            begin
                stall_left--;
                pop <= 1'b0;
            end
            else if (stall_mode == STALL_HEAVY && $urandom_range(0, 2) == 0)
            begin
                stall_left = $urandom_range(0, 24);
                pop <= 1'b0;
            end
            else if (stall_mode == STALL_LIGHT && $urandom_range(0, 4) == 0)
            begin
                stall_left = $urandom_range(0, 2);
                pop <= 1'b0;
            end
            else
                pop <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((push && !full) || (pop && !empty))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_send_extremes();
        test_info_reply_after_crc_error();
        test_random_traffic(50, 1'b1, STALL_LIGHT);
        hold_until_drained();
        test_random_traffic(40, 1'b0, STALL_NONE);
        test_random_traffic(40, 1'b1, STALL_HEAVY);
        stall_mode = STALL_LIGHT;
        hold_until_drained();
        // keep popping for a while to catch stray beats
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
